// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_SAME_CYCLE(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tctk assertion failed");

// next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT_CYCLE(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tctk assertion failed");

`endif

// ----- rtl/tctk_pkg.sv -----
`timescale 1ns / 1ps

package tctk_pkg;

    // sizing
    localparam int NUM_PHYS_REGS = 256;
    localparam int CHAIN_DEPTH   = 16;
    localparam int DONE_DEPTH    = 16;
    localparam int PC_W          = 48;
    localparam int REG_W         = 8;
    localparam int NSRC_W        = 2;
    localparam int NSRC          = 3;
    localparam int STATUS_W      = 3;
    localparam int CHIDX_W       = 4;
    localparam int QUEUE_DEPTH   = 2;   // power of two, pointers wrap by overflow

    localparam int TIDX_W = (NUM_PHYS_REGS > 1) ? $clog2(NUM_PHYS_REGS) : 1;
    localparam int CNT_W  = $clog2(CHAIN_DEPTH + 1);
    localparam int CIDX_W = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
    localparam int DIDX_W = (DONE_DEPTH > 1) ? $clog2(DONE_DEPTH) : 1;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // opcodes
    localparam logic OP_START  = 1'b0;
    localparam logic OP_RENAME = 1'b1;

    typedef logic [PC_W-1:0]   t_pc;
    typedef logic [TIDX_W-1:0] t_tidx;

    typedef enum logic [STATUS_W-1:0] {
        ST_STARTED   = 3'd0,
        ST_REFUSED   = 3'd1,
        ST_PROCESSED = 3'd2,
        ST_IGNORED   = 3'd3,
        ST_CHAIN     = 3'd4
    } t_status;

    // classified word handed from front to back
    typedef struct packed {
        logic                         is_start;
        logic                         start_ok;
        t_pc                          pc;
        logic [NSRC-1:0]              src_use;
        logic [NSRC-1:0][TIDX_W-1:0]  src_idx;
        logic                         dest_ok;
        t_tidx                        dest_idx;
        logic                         is_load;
    } t_item;

    // one result word
    typedef struct packed {
        t_status              status;
        logic                 src_tainted;
        logic                 dest_tainted;
        t_pc                  base_pc;
        t_pc                  chain_pc;
        logic [CHIDX_W-1:0]   chain_index;
        logic                 chain_overflowed;
        logic                 last;
    } t_result;

    typedef enum logic [1:0] {
        S_RUN  = 2'b01,
        S_EMIT = 2'b10
    } t_bstate;

    // register index lies inside the physical file
    function automatic logic reg_in_range(input logic [REG_W-1:0] r);
        return int'(r) < NUM_PHYS_REGS;
    endfunction

endpackage

// ----- rtl/tctk_front.sv -----
`timescale 1ns / 1ps

module tctk_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_opcode,
    input  logic [tctk_pkg::PC_W-1:0]         i_pc,
    input  logic                              i_is_stride_pc,
    input  logic [tctk_pkg::NSRC_W-1:0]       i_num_srcs,
    input  logic [tctk_pkg::REG_W-1:0]        i_src_a_reg,
    input  logic [tctk_pkg::REG_W-1:0]        i_src_b_reg,
    input  logic [tctk_pkg::REG_W-1:0]        i_src_c_reg,
    input  logic                              i_has_dest,
    input  logic [tctk_pkg::REG_W-1:0]        i_dest_reg,
    input  logic                              i_is_load,
    input  logic                              i_q_full,
    output logic                              o_item_vld,
    output tctk_pkg::t_item                   o_item
);
    import tctk_pkg::*;

    logic  r_vld, n_vld;
    t_item r_item, n_item;
    logic  w_accept;
    logic  w_push;
    logic  w_dest_ok;
    logic [REG_W-1:0] w_src [NSRC];

    // handshake: hold the word until the queue takes it
    assign busy     = r_vld && i_q_full;
    assign w_accept = start && !busy;
    assign w_push   = r_vld && !i_q_full;

    assign o_item_vld = r_vld;
    assign o_item     = r_item;

    // classify the incoming word
    always_comb begin
        w_src[0]  = i_src_a_reg;
        w_src[1]  = i_src_b_reg;
        w_src[2]  = i_src_c_reg;
        w_dest_ok = i_has_dest && reg_in_range(i_dest_reg);

        n_item          = '0;
        n_item.is_start = (i_opcode == OP_START);
        n_item.start_ok = i_is_stride_pc && w_dest_ok;
        n_item.pc       = i_pc;
        for (int k = 0; k < NSRC; k++) begin
            n_item.src_use[k] = (k < int'(i_num_srcs)) && reg_in_range(w_src[k]);
            n_item.src_idx[k] = TIDX_W'(w_src[k]);
        end
        n_item.dest_ok  = w_dest_ok;
        n_item.dest_idx = TIDX_W'(i_dest_reg);
        n_item.is_load  = i_is_load;
    end

    // stage valid
    always_comb begin
        n_vld = r_vld;
        if (w_accept) begin
            n_vld = 1'b1;
        end else if (w_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // payload stage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- rtl/tctk_queue.sv -----
`timescale 1ns / 1ps

module tctk_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_vld,
    input  tctk_pkg::t_item   i_push_item,
    output logic              o_full,
    output logic              o_vld,
    output tctk_pkg::t_item   o_item,
    input  logic              i_pop
);
    import tctk_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic                w_push;
    logic                w_pop;

    assign o_full = (int'(r_cnt) == QUEUE_DEPTH);
    assign o_vld  = (r_cnt != '0);
    assign o_item = r_mem[r_rd_ptr];
    assign w_push = i_push_vld && !o_full;
    assign w_pop  = i_pop && o_vld;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ----- rtl/tctk_back.sv -----
`timescale 1ns / 1ps

module tctk_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  tctk_pkg::t_item    i_item,
    output logic               o_pop,
    output logic               o_res_vld,
    output tctk_pkg::t_result  o_res
);
    import tctk_pkg::*;

    // session and taint state
    logic [NUM_PHYS_REGS-1:0] r_taint, n_taint;
    logic                     r_active, n_active;
    t_pc                      r_base, n_base;
    logic                     r_base_done, n_base_done;

    // chain store, kept sorted
    t_pc                      r_chain [CHAIN_DEPTH];
    t_pc                      n_chain [CHAIN_DEPTH];
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_full, n_full;

    // completed stride list
    t_pc                      r_done_pc [DONE_DEPTH];
    t_pc                      n_done_pc [DONE_DEPTH];
    logic [DONE_DEPTH-1:0]    r_done_vld, n_done_vld;
    logic [DIDX_W-1:0]        r_done_slot, n_done_slot;

    // sequencer and output register
    t_bstate                  r_state, n_state;
    logic [CIDX_W-1:0]        r_emit_idx, n_emit_idx;
    logic                     r_out_vld, n_out_vld;
    t_result                  r_out, n_out;

    // datapath intermediates
    logic                     w_st;
    logic                     w_done_hit;
    logic [CHAIN_DEPTH-1:0]   w_lt;
    logic [CHAIN_DEPTH-1:0]   w_eq;
    logic [CNT_W-1:0]         w_pos;
    t_pc                      w_ins [CHAIN_DEPTH];
    logic                     w_emit_last;

    assign o_pop     = (r_state == S_RUN) && i_vld;
    assign o_res_vld = r_out_vld;
    assign o_res     = r_out;

    // source taint lookup
    always_comb begin
        w_st = 1'b0;
        for (int k = 0; k < NSRC; k++) begin
            w_st = w_st || (i_item.src_use[k] && r_taint[i_item.src_idx[k]]);
        end
    end

    // completed-list search for a new stride pc
    always_comb begin
        w_done_hit = 1'b0;
        for (int d = 0; d < DONE_DEPTH; d++) begin
            w_done_hit = w_done_hit || (r_done_vld[d] && (r_done_pc[d] == i_item.pc));
        end
    end

    // sorted insert position and shifted copy of the chain
    always_comb begin
        for (int i = 0; i < CHAIN_DEPTH; i++) begin
            w_lt[i] = (i < int'(r_cnt)) && (r_chain[i] < i_item.pc);
            w_eq[i] = (i < int'(r_cnt)) && (r_chain[i] == i_item.pc);
        end
        w_pos = CNT_W'($countones(w_lt));
        for (int i = 0; i < CHAIN_DEPTH; i++) begin
            w_ins[i] = r_chain[i];
        end
        for (int i = 1; i < CHAIN_DEPTH; i++) begin
            if (i > int'(w_pos)) begin
                w_ins[i] = r_chain[i-1];
            end
        end
        for (int i = 0; i < CHAIN_DEPTH; i++) begin
            if (i == int'(w_pos)) begin
                w_ins[i] = i_item.pc;
            end
        end
    end

    assign w_emit_last = ((CNT_W'(r_emit_idx) + 1'b1) == r_cnt);

    // item execution and chain emission
    always_comb begin
        n_taint     = r_taint;
        n_active    = r_active;
        n_base      = r_base;
        n_base_done = r_base_done;
        n_chain     = r_chain;
        n_cnt       = r_cnt;
        n_full      = r_full;
        n_done_pc   = r_done_pc;
        n_done_vld  = r_done_vld;
        n_done_slot = r_done_slot;
        n_state     = r_state;
        n_emit_idx  = r_emit_idx;
        n_out_vld   = 1'b0;
        n_out       = '0;
        n_out.last  = 1'b1;

        case (r_state)
            S_RUN: begin
                if (i_vld) begin
                    if (i_item.is_start) begin
                        // session start from a stride load
                        n_out_vld = 1'b1;
                        if (i_item.start_ok) begin
                            n_taint[i_item.dest_idx] = 1'b1;
                            n_base       = i_item.pc;
                            n_base_done  = w_done_hit;
                            n_chain[0]   = i_item.pc;
                            n_cnt        = CNT_W'(1);
                            n_full       = 1'b0;
                            n_active     = 1'b1;
                            n_out.status       = ST_STARTED;
                            n_out.dest_tainted = 1'b1;
                            n_out.base_pc      = i_item.pc;
                        end else begin
                            n_out.status = ST_REFUSED;
                        end
                    end else if (!r_active) begin
                        n_out_vld     = 1'b1;
                        n_out.status  = ST_IGNORED;
                        n_out.base_pc = r_base;
                    end else if (r_base_done) begin
                        // stride pc already completed: drop the session
                        n_active      = 1'b0;
                        n_out_vld     = 1'b1;
                        n_out.status  = ST_IGNORED;
                        n_out.base_pc = r_base;
                    end else begin
                        // chain grows on a tainted source
                        if (w_st && !(|w_eq)) begin
                            if (int'(r_cnt) >= CHAIN_DEPTH) begin
                                n_full = 1'b1;
                            end else begin
                                n_chain = w_ins;
                                n_cnt   = r_cnt + 1'b1;
                            end
                        end
                        if (i_item.dest_ok) begin
                            n_taint[i_item.dest_idx] = w_st;
                        end
                        if (i_item.is_load && w_st) begin
                            // detection: clear taints, close session, log stride pc
                            n_taint                  = '0;
                            n_active                 = 1'b0;
                            n_done_pc[r_done_slot]   = r_base;
                            n_done_vld[r_done_slot]  = 1'b1;
                            if (int'(r_done_slot) == DONE_DEPTH - 1) begin
                                n_done_slot = '0;
                            end else begin
                                n_done_slot = r_done_slot + 1'b1;
                            end
                            n_emit_idx = '0;
                            n_state    = S_EMIT;
                        end else begin
                            n_out_vld          = 1'b1;
                            n_out.status       = ST_PROCESSED;
                            n_out.src_tainted  = w_st;
                            n_out.dest_tainted = i_item.dest_ok && w_st;
                            n_out.base_pc      = r_base;
                        end
                    end
                end
            end
            S_EMIT: begin
                // one chain entry per cycle, ascending
                n_out_vld              = 1'b1;
                n_out.status           = ST_CHAIN;
                n_out.src_tainted      = 1'b1;
                n_out.base_pc          = r_base;
                n_out.chain_pc         = r_chain[r_emit_idx];
                n_out.chain_index      = CHIDX_W'(r_emit_idx);
                n_out.chain_overflowed = r_full;
                n_out.last             = w_emit_last;
                if (w_emit_last) begin
                    n_state = S_RUN;
                end else begin
                    n_emit_idx = r_emit_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taint     <= '0;
            r_active    <= 1'b0;
            r_base      <= '0;
            r_base_done <= 1'b0;
            r_cnt       <= '0;
            r_full      <= 1'b0;
            r_done_vld  <= '0;
            r_done_slot <= '0;
            r_state     <= S_RUN;
            r_emit_idx  <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_taint     <= n_taint;
            r_active    <= n_active;
            r_base      <= n_base;
            r_base_done <= n_base_done;
            r_cnt       <= n_cnt;
            r_full      <= n_full;
            r_done_vld  <= n_done_vld;
            r_done_slot <= n_done_slot;
            r_state     <= n_state;
            r_emit_idx  <= n_emit_idx;
            r_out_vld   <= n_out_vld;
        end
    end

    // payload stores
    always_ff @(posedge i_clk) begin
        r_chain   <= n_chain;
        r_done_pc <= n_done_pc;
        r_out     <= n_out;
    end

endmodule

// ----- rtl/register_taint_chain_tracker_unit.sv -----
`timescale 1ns / 1ps

// Register taint chain tracker. An item is taken when start is high and busy is
// low; each result word shows on the o_ ports for one cycle with o_valid high and
// cannot be held off by the receiver. A front stage classifies the word and hands
// it through a two-entry queue to the back unit, which executes one item per
// cycle unless emitting a chain. An item passes the front stage register and a
// queue entry, and the back unit registers its result. A chain-closing load puts
// the back unit in an emit state that takes no item and emits its n (1 to 16)
// entries, one per cycle from the chain store; busy rises once the queue and
// front stage are full. No clearing pass follows reset: items are taken at once.
module register_taint_chain_tracker_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_opcode,
    input  logic [tctk_pkg::PC_W-1:0]         i_pc,
    input  logic                              i_is_stride_pc,
    input  logic [tctk_pkg::NSRC_W-1:0]       i_num_srcs,
    input  logic [tctk_pkg::REG_W-1:0]        i_src_a_reg,
    input  logic [tctk_pkg::REG_W-1:0]        i_src_b_reg,
    input  logic [tctk_pkg::REG_W-1:0]        i_src_c_reg,
    input  logic                              i_has_dest,
    input  logic [tctk_pkg::REG_W-1:0]        i_dest_reg,
    input  logic                              i_is_load,
    output logic                              o_valid,
    output logic [tctk_pkg::STATUS_W-1:0]     o_status,
    output logic                              o_src_tainted,
    output logic                              o_dest_tainted,
    output logic [tctk_pkg::PC_W-1:0]         o_base_pc,
    output logic [tctk_pkg::PC_W-1:0]         o_chain_pc,
    output logic [tctk_pkg::CHIDX_W-1:0]      o_chain_index,
    output logic                              o_chain_overflowed,
    output logic                              o_last
);
    import tctk_pkg::*;

    logic    w_f_vld;
    t_item   w_f_item;
    logic    w_q_full;
    logic    w_q_vld;
    t_item   w_q_item;
    logic    w_pop;
    logic    w_res_vld;
    t_result w_res;

    // front: accept and classify
    tctk_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_pc           (i_pc),
        .i_is_stride_pc (i_is_stride_pc),
        .i_num_srcs     (i_num_srcs),
        .i_src_a_reg    (i_src_a_reg),
        .i_src_b_reg    (i_src_b_reg),
        .i_src_c_reg    (i_src_c_reg),
        .i_has_dest     (i_has_dest),
        .i_dest_reg     (i_dest_reg),
        .i_is_load      (i_is_load),
        .i_q_full       (w_q_full),
        .o_item_vld     (w_f_vld),
        .o_item         (w_f_item)
    );

    // decoupling queue
    tctk_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_vld  (w_f_vld),
        .i_push_item (w_f_item),
        .o_full      (w_q_full),
        .o_vld       (w_q_vld),
        .o_item      (w_q_item),
        .i_pop       (w_pop)
    );

    // back: execute and emit
    tctk_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (w_q_vld),
        .i_item    (w_q_item),
        .o_pop     (w_pop),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    // result ports
    assign o_valid            = w_res_vld;
    assign o_status           = w_res.status;
    assign o_src_tainted      = w_res.src_tainted;
    assign o_dest_tainted     = w_res.dest_tainted;
    assign o_base_pc          = w_res.base_pc;
    assign o_chain_pc         = w_res.chain_pc;
    assign o_chain_index      = w_res.chain_index;
    assign o_chain_overflowed = w_res.chain_overflowed;
    assign o_last             = w_res.last;

endmodule

// ----- rtl/tctk_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tctk_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [tctk_pkg::STATUS_W-1:0]     i_status,
    input  logic                              i_src_tainted,
    input  logic                              i_dest_tainted,
    input  logic [tctk_pkg::PC_W-1:0]         i_base_pc,
    input  logic [tctk_pkg::PC_W-1:0]         i_chain_pc,
    input  logic [tctk_pkg::CHIDX_W-1:0]      i_chain_index,
    input  logic                              i_chain_overflowed,
    input  logic                              i_last
);
    import tctk_pkg::*;

    // chain words come after all taints are cleared
    `ASSERT_SAME_CYCLE(a_chain_taint, i_clk, i_rst_n, i_valid && (i_status == ST_CHAIN), i_src_tainted && !i_dest_tainted)

    // every other word stands alone with empty chain fields
    `ASSERT_SAME_CYCLE(a_single_word, i_clk, i_rst_n, i_valid && (i_status != ST_CHAIN), i_last && (i_chain_pc == '0) && (i_chain_index == '0) && !i_chain_overflowed)

    // chain run is unbroken, counts up and keeps its stride pc
    `ASSERT_NEXT_CYCLE(a_chain_run, i_clk, i_rst_n, i_valid && (i_status == ST_CHAIN) && !i_last, i_valid && (i_status == ST_CHAIN) && (i_chain_index == CHIDX_W'($past(i_chain_index) + 1'b1)) && $stable(i_base_pc))

    // refused start carries no session
    `ASSERT_SAME_CYCLE(a_refused, i_clk, i_rst_n, i_valid && (i_status == ST_REFUSED), (i_base_pc == '0) && !i_dest_tainted && !i_src_tainted)

endmodule

bind register_taint_chain_tracker_unit tctk_checker u_tctk_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (o_valid),
    .i_status           (o_status),
    .i_src_tainted      (o_src_tainted),
    .i_dest_tainted     (o_dest_tainted),
    .i_base_pc          (o_base_pc),
    .i_chain_pc         (o_chain_pc),
    .i_chain_index      (o_chain_index),
    .i_chain_overflowed (o_chain_overflowed),
    .i_last             (o_last)
);
